/* hdl/lphf_pkg.sv */
`timescale 1ns / 1ps

package lphf_pkg;

    localparam int KEY_W   = 64;
    localparam int ENTRY_W = 11;
    localparam int COUNT_W = 12;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    localparam logic OP_LOOKUP = 1'b0;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_PROBE  = 6'b000100,
        S_GSCAN  = 6'b001000,
        S_GPROBE = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

endpackage

/* hdl/lphf_slot_ram.sv */
`timescale 1ns / 1ps

module lphf_slot_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 80
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first on a same-address read
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/linear_probe_hash_find_insert.sv */
`timescale 1ns / 1ps

// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_op, i_key
// output  | o_valid | i_stall | o_status, o_entry_id, o_entry_count
//
// an item is accepted, then the linear probe reads one slot at a time from the slot ram,
// and the result goes to the output register once that register is free
// an insert that doubles the table first scans every old slot and probes the new bank
// for each moved key, one read at a time; the single read port of the slot ram sets this pace
// after reset a clearing pass writes all 2 * 2^clog2(MAX_SLOTS) ram words; no items are taken until it ends
// o_stall is high whenever the block is busy; a result waiting on i_stall does not block the next item

module linear_probe_hash_find_insert #(
    parameter int INITIAL_SLOTS = 256,
    parameter int MAX_SLOTS     = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [lphf_pkg::KEY_W-1:0]    i_key,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lphf_pkg::STAT_W-1:0]   o_status,
    output logic [lphf_pkg::ENTRY_W-1:0]  o_entry_id,
    output logic [lphf_pkg::COUNT_W-1:0]  o_entry_count
);

    // slot index width, size-log width and epoch tag width
    localparam int AW       = $clog2(MAX_SLOTS);
    localparam int LW       = $clog2(AW + 1);
    localparam int EW       = $clog2(AW + 3);
    localparam int INIT_MIN = (INITIAL_SLOTS < MAX_SLOTS) ? INITIAL_SLOTS : MAX_SLOTS;
    localparam int INIT_LOG = $clog2(INIT_MIN + 1) - 1;
    localparam int KW       = lphf_pkg::KEY_W;
    localparam int NW       = lphf_pkg::ENTRY_W;
    localparam int DW       = EW + NW + KW;

    lphf_pkg::t_state r_state, n_state;

    logic              r_op, n_op;
    logic [KW-1:0]     r_key, n_key;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW:0]       r_n, n_n;
    logic              r_grown, n_grown;
    logic              r_bank, n_bank;
    logic [EW-1:0]     r_epoch, n_epoch;
    logic [EW-1:0]     r_old_epoch, n_old_epoch;
    logic [LW-1:0]     r_log, n_log;
    logic [AW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_scan, n_scan;
    logic [KW-1:0]     r_mkey, n_mkey;
    logic [NW-1:0]     r_ment, n_ment;
    logic [AW:0]       r_clr, n_clr;
    logic [lphf_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic [NW-1:0]     r_res_id, n_res_id;
    logic              r_ovalid, n_ovalid;
    logic [lphf_pkg::STAT_W-1:0] r_ostatus, n_ostatus;
    logic [NW-1:0]     r_oid, n_oid;
    logic [lphf_pkg::COUNT_W-1:0] r_ocount, n_ocount;

    logic              ram_we;
    logic [AW:0]       ram_waddr, ram_raddr;
    logic [DW-1:0]     ram_wdata, ram_rdata;

    logic [EW-1:0]     rd_tag;
    logic [NW-1:0]     rd_entry;
    logic [KW-1:0]     rd_key;

    logic [AW:0]       size;
    logic [AW-1:0]     mask;
    logic              grow_due;
    logic              scan_next;
    logic              scan_last;

    lphf_slot_ram #(
        .ADDR_W (AW + 1),
        .DATA_W (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_tag   = ram_rdata[DW-1 -: EW];
    assign rd_entry = ram_rdata[KW +: NW];
    assign rd_key   = ram_rdata[KW-1:0];

    // active size and home mask follow the size log
    assign size     = (AW + 1)'(1) << r_log;
    assign mask     = AW'(size - (AW + 1)'(1));
    assign grow_due = (AW + 1)'({r_count, 1'b0}) >= size;
    // during growth the old table is half the active size
    assign scan_last = r_scan == AW'((size >> 1) - (AW + 1)'(1));

    assign o_stall = r_state != lphf_pkg::S_IDLE;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_n          = r_n;
        n_grown      = r_grown;
        n_bank       = r_bank;
        n_epoch      = r_epoch;
        n_old_epoch  = r_old_epoch;
        n_log        = r_log;
        n_count      = r_count;
        n_scan       = r_scan;
        n_mkey       = r_mkey;
        n_ment       = r_ment;
        n_clr        = r_clr;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_ovalid     = r_ovalid & i_stall;
        n_ostatus    = r_ostatus;
        n_oid        = r_oid;
        n_ocount     = r_ocount;
        ram_we       = 1'b0;
        ram_waddr    = {r_bank, r_idx};
        ram_wdata    = {r_epoch, r_ment, r_mkey};
        ram_raddr    = {r_bank, r_idx};
        scan_next    = 1'b0;

        case (r_state)
            lphf_pkg::S_CLEAR: begin
                // tag zero never matches a live epoch
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + (AW + 1)'(1);
                if (&r_clr) begin
                    n_state = lphf_pkg::S_IDLE;
                end
            end
            lphf_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op      = i_op;
                    n_key     = i_key;
                    n_idx     = i_key[AW-1:0] & mask;
                    n_n       = '0;
                    n_grown   = 1'b0;
                    ram_raddr = {r_bank, i_key[AW-1:0] & mask};
                    n_state   = lphf_pkg::S_PROBE;
                end
            end
            lphf_pkg::S_PROBE: begin
                if ((rd_tag == r_epoch) && (rd_key == r_key)) begin
                    n_res_status = lphf_pkg::ST_FOUND;
                    n_res_id     = rd_entry;
                    n_state      = lphf_pkg::S_DONE;
                end else if ((rd_tag == r_epoch) && ((r_n + (AW + 1)'(1)) != size)) begin
                    // occupied by another key: next slot with wraparound
                    n_idx     = (r_idx + AW'(1)) & mask;
                    n_n       = r_n + (AW + 1)'(1);
                    ram_raddr = {r_bank, (r_idx + AW'(1)) & mask};
                end else if (r_op == lphf_pkg::OP_LOOKUP) begin
                    n_res_status = lphf_pkg::ST_ABSENT;
                    n_res_id     = '0;
                    n_state      = lphf_pkg::S_DONE;
                end else if (!r_grown && grow_due) begin
                    if (size < (AW + 1)'(MAX_SLOTS)) begin
                        // double into the other bank under a fresh epoch
                        n_old_epoch = r_epoch;
                        n_epoch     = r_epoch + EW'(1);
                        n_bank      = ~r_bank;
                        n_log       = r_log + LW'(1);
                        n_scan      = '0;
                        ram_raddr   = {r_bank, {AW{1'b0}}};
                        n_state     = lphf_pkg::S_GSCAN;
                    end else begin
                        n_res_status = lphf_pkg::ST_FULL;
                        n_res_id     = '0;
                        n_state      = lphf_pkg::S_DONE;
                    end
                end else if (rd_tag != r_epoch) begin
                    ram_we       = 1'b1;
                    ram_wdata    = {r_epoch, NW'(r_count), r_key};
                    n_count      = r_count + AW'(1);
                    n_res_status = lphf_pkg::ST_INSERTED;
                    n_res_id     = NW'(r_count);
                    n_state      = lphf_pkg::S_DONE;
                end else begin
                    // probe bound reached with no free slot
                    n_res_status = lphf_pkg::ST_FULL;
                    n_res_id     = '0;
                    n_state      = lphf_pkg::S_DONE;
                end
            end
            lphf_pkg::S_GSCAN: begin
                if (rd_tag == r_old_epoch) begin
                    n_mkey    = rd_key;
                    n_ment    = rd_entry;
                    n_idx     = rd_key[AW-1:0] & mask;
                    ram_raddr = {r_bank, rd_key[AW-1:0] & mask};
                    n_state   = lphf_pkg::S_GPROBE;
                end else begin
                    scan_next = 1'b1;
                end
            end
            lphf_pkg::S_GPROBE: begin
                if (rd_tag != r_epoch) begin
                    ram_we    = 1'b1;
                    scan_next = 1'b1;
                end else begin
                    n_idx     = (r_idx + AW'(1)) & mask;
                    ram_raddr = {r_bank, (r_idx + AW'(1)) & mask};
                end
            end
            lphf_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res_status;
                    n_oid     = r_res_id;
                    n_ocount  = lphf_pkg::COUNT_W'(r_count);
                    n_state   = lphf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lphf_pkg::S_IDLE;
            end
        endcase

        if (scan_next) begin
            if (scan_last) begin
                // re-placement finished: probe the pending key again
                n_idx     = r_key[AW-1:0] & mask;
                n_n       = '0;
                n_grown   = 1'b1;
                ram_raddr = {r_bank, r_key[AW-1:0] & mask};
                n_state   = lphf_pkg::S_PROBE;
            end else begin
                n_scan    = r_scan + AW'(1);
                ram_raddr = {~r_bank, r_scan + AW'(1)};
                n_state   = lphf_pkg::S_GSCAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lphf_pkg::S_CLEAR;
            r_bank   <= 1'b0;
            r_epoch  <= EW'(1);
            r_log    <= LW'(INIT_LOG);
            r_count  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_epoch  <= n_epoch;
            r_log    <= n_log;
            r_count  <= n_count;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_n          <= n_n;
        r_grown      <= n_grown;
        r_old_epoch  <= n_old_epoch;
        r_scan       <= n_scan;
        r_mkey       <= n_mkey;
        r_ment       <= n_ment;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_ostatus    <= n_ostatus;
        r_oid        <= n_oid;
        r_ocount     <= n_ocount;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_entry_id    = r_oid;
    assign o_entry_count = r_ocount;

endmodule
